// ----- rtl/caip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caip_pkg: shared types and constants of the circular arc step interpolator
// Widths, opcode and quadrant codes, and the per-quadrant step direction
// tables that the arc datapath uses.
// ----------------------------------------------------------------------------
package caip_pkg;

  localparam int COORD_BITS = 16;
  localparam int TERM_BITS  = COORD_BITS + 2;
  localparam int STEP_BITS  = COORD_BITS + 2;
  localparam int DEV_BITS   = ((2 * COORD_BITS + 4) > 63) ? 63 : (2 * COORD_BITS + 4);
  localparam int QUAD_BITS  = 4;

  // Command opcodes; the unused code falls to the default arm
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_ABORT = 2'd2
  } opcode_t;

  // Quadrant codes: SR = clockwise, NR = counterclockwise
  localparam logic [QUAD_BITS-1:0] QUAD_NONE = 4'd0;
  localparam logic [QUAD_BITS-1:0] QUAD_SR1  = 4'd1;
  localparam logic [QUAD_BITS-1:0] QUAD_SR2  = 4'd2;
  localparam logic [QUAD_BITS-1:0] QUAD_SR3  = 4'd3;
  localparam logic [QUAD_BITS-1:0] QUAD_SR4  = 4'd4;
  localparam logic [QUAD_BITS-1:0] QUAD_NR1  = 4'd5;
  localparam logic [QUAD_BITS-1:0] QUAD_NR2  = 4'd6;
  localparam logic [QUAD_BITS-1:0] QUAD_NR3  = 4'd7;
  localparam logic [QUAD_BITS-1:0] QUAD_NR4  = 4'd8;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // Decoded load word
  typedef struct packed {
    logic [QUAD_BITS-1:0] quadrant;
    logic [STEP_BITS-1:0] steps;
    logic [TERM_BITS-1:0] x_term;
    logic [TERM_BITS-1:0] y_term;
  } load_t;

  // Step axis for a quadrant, given the sign of the deviation
  function automatic logic step_axis_f(input logic [QUAD_BITS-1:0] q, input logic neg);
    logic a;
    a = AXIS_X;
    case (q)
      QUAD_SR1, QUAD_SR3, QUAD_NR2, QUAD_NR4: a = neg ? AXIS_X : AXIS_Y;
      QUAD_SR2, QUAD_SR4, QUAD_NR1, QUAD_NR3: a = neg ? AXIS_Y : AXIS_X;
      default:                                a = AXIS_X;
    endcase
    return a;
  endfunction

  // Step direction (1 = reverse) for a quadrant, given the deviation sign
  function automatic logic step_rev_f(input logic [QUAD_BITS-1:0] q, input logic neg);
    logic r;
    r = 1'b0;
    case (q)
      QUAD_SR1, QUAD_NR1: r = !neg;
      QUAD_SR3, QUAD_NR3: r = neg;
      QUAD_SR4, QUAD_NR2: r = 1'b1;
      default:            r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/circular_arc_step_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_arc_step_interpolator: point-by-point circular arc stepper
// Loads an arc and issues one X or Y step per tick word while steps remain.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one command word: load arc,
//   tick for one step, or abort. Every accepted word yields exactly one
//   result word on the output channel (out_valid / out_ready) giving the
//   step pulse, its axis and direction, and the run-done flag.
//   The result is presented in the cycle after the word is accepted.
//   Throughput: one word per cycle unless stalled. The arc state (deviation,
//   radius terms, step count, quadrant) is updated in the accepting cycle by
//   one doubled-term add and two counts, so consecutive ticks need no gap.
//   Stall: the single output register holds its word while out_ready is
//   low; in_ready follows out_ready when that register is full, so a word is
//   taken in the same cycle the pending result leaves.
//   Reset (rst_n low, synchronous): the output register empties, the
//   quadrant, deviation, radius terms and step count clear; a tick before
//   the first load reports no step and run done.
// ----------------------------------------------------------------------------
module circular_arc_step_interpolator import caip_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_opcode,
  input  logic                         in_arc_clockwise,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_center_offset_i,
  input  logic signed [COORD_BITS-1:0] in_center_offset_j,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_step_valid,
  output logic                         out_step_axis,
  output logic                         out_step_reverse,
  output logic                         out_run_done
);

  // Arc state
  logic [QUAD_BITS-1:0] quad_r, quad_nxt;
  logic [DEV_BITS-1:0]  dev_r, dev_nxt;
  logic [TERM_BITS-1:0] xterm_r, xterm_nxt;
  logic [TERM_BITS-1:0] yterm_r, yterm_nxt;
  logic [STEP_BITS-1:0] steps_r, steps_nxt;

  // Result register
  logic out_valid_r, out_valid_nxt;
  logic step_valid_r, step_valid_nxt;
  logic axis_r, axis_nxt;
  logic rev_r, rev_nxt;
  logic done_r, done_nxt;

  logic                 accept;
  load_t                load;
  logic                 neg;
  logic                 tick_axis;
  logic                 tick_rev;
  logic [TERM_BITS-1:0] term_sel;
  logic [DEV_BITS-1:0]  twice;
  logic                 can_step;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  caip_load_dec u_load_dec (
    .arc_clockwise  (in_arc_clockwise),
    .start_x        (in_start_x),
    .start_y        (in_start_y),
    .end_x          (in_end_x),
    .end_y          (in_end_y),
    .center_offset_i(in_center_offset_i),
    .center_offset_j(in_center_offset_j),
    .load           (load)
  );

  // Tick datapath: direction lookup and doubled term
  assign neg       = dev_r[DEV_BITS-1];
  assign tick_axis = step_axis_f(quad_r, neg);
  assign tick_rev  = step_rev_f(quad_r, neg);
  assign term_sel  = (tick_axis == AXIS_Y) ? yterm_r : xterm_r;
  assign twice     = {{(DEV_BITS-TERM_BITS-1){term_sel[TERM_BITS-1]}}, term_sel, 1'b0};
  assign can_step  = (steps_r != '0) && (quad_r != QUAD_NONE) && (quad_r <= QUAD_NR4);

  // Next state and result
  always_comb begin
    quad_nxt       = quad_r;
    dev_nxt        = dev_r;
    xterm_nxt      = xterm_r;
    yterm_nxt      = yterm_r;
    steps_nxt      = steps_r;
    step_valid_nxt = 1'b0;
    axis_nxt       = 1'b0;
    rev_nxt        = 1'b0;
    case (in_opcode)
      OP_LOAD: begin
        quad_nxt  = load.quadrant;
        steps_nxt = load.steps;
        dev_nxt   = '0;
        xterm_nxt = load.x_term;
        yterm_nxt = load.y_term;
      end
      OP_TICK: begin
        if (can_step) begin
          step_valid_nxt = 1'b1;
          axis_nxt       = tick_axis;
          rev_nxt        = tick_rev;
          if (neg) begin
            dev_nxt = dev_r + twice;
          end else begin
            dev_nxt = dev_r - twice;
          end
          if (tick_axis == AXIS_Y) begin
            yterm_nxt = neg ? yterm_r + 1'b1 : yterm_r - 1'b1;
          end else begin
            xterm_nxt = neg ? xterm_r + 1'b1 : xterm_r - 1'b1;
          end
          steps_nxt = steps_r - 1'b1;
        end
      end
      OP_ABORT: begin
        steps_nxt = '0;
        quad_nxt  = QUAD_NONE;
      end
      default: begin
      end
    endcase
    done_nxt = (steps_nxt == '0);
  end

  assign out_valid_nxt = accept ? 1'b1 : (out_valid_r && !out_ready);

  // Control and arc state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      quad_r      <= QUAD_NONE;
      dev_r       <= '0;
      xterm_r     <= '0;
      yterm_r     <= '0;
      steps_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        quad_r  <= quad_nxt;
        dev_r   <= dev_nxt;
        xterm_r <= xterm_nxt;
        yterm_r <= yterm_nxt;
        steps_r <= steps_nxt;
      end
    end
  end

  // Result word payload
  always_ff @(posedge clk) begin
    if (accept) begin
      step_valid_r <= step_valid_nxt;
      axis_r       <= axis_nxt;
      rev_r        <= rev_nxt;
      done_r       <= done_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_step_valid   = step_valid_r;
  assign out_step_axis    = axis_r;
  assign out_step_reverse = rev_r;
  assign out_run_done     = done_r;

endmodule

// ----- rtl/caip_load_dec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caip_load_dec: arc load decoder
// Picks the quadrant code from the chord signs and the direction, and forms
// the step count and the radius term seeds from the load word.
// ----------------------------------------------------------------------------
module caip_load_dec import caip_pkg::*; (
  input  logic                         arc_clockwise,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] center_offset_i,
  input  logic signed [COORD_BITS-1:0] center_offset_j,
  output load_t                        load
);

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS:0]        dx_mag;
  logic [COORD_BITS:0]        dy_mag;
  logic signed [COORD_BITS:0] i_ext;
  logic signed [COORD_BITS:0] j_ext;
  logic [COORD_BITS:0]        i_mag;
  logic [COORD_BITS:0]        j_mag;
  logic                       xge, xle, yge, yle;

  // Chord and its magnitudes
  assign dx     = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
  assign dy     = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
  assign dx_mag = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
  assign dy_mag = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;

  assign xge = !dx[COORD_BITS];
  assign xle = dx[COORD_BITS] || (dx == '0);
  assign yge = !dy[COORD_BITS];
  assign yle = dy[COORD_BITS] || (dy == '0);

  // Center offset magnitudes
  assign i_ext = {center_offset_i[COORD_BITS-1], center_offset_i};
  assign j_ext = {center_offset_j[COORD_BITS-1], center_offset_j};
  assign i_mag = i_ext[COORD_BITS] ? (COORD_BITS+1)'(-i_ext) : i_ext;
  assign j_mag = j_ext[COORD_BITS] ? (COORD_BITS+1)'(-j_ext) : j_ext;

  // Quadrant in tie order
  always_comb begin
    if (xge && yge) begin
      load.quadrant = arc_clockwise ? QUAD_SR2 : QUAD_NR4;
    end else if (xle && yge) begin
      load.quadrant = arc_clockwise ? QUAD_SR3 : QUAD_NR1;
    end else if (xle && yle) begin
      load.quadrant = arc_clockwise ? QUAD_SR4 : QUAD_NR2;
    end else begin
      load.quadrant = arc_clockwise ? QUAD_SR1 : QUAD_NR3;
    end
  end

  assign load.steps  = STEP_BITS'(dx_mag) + STEP_BITS'(dy_mag);
  assign load.x_term = TERM_BITS'(i_mag);
  assign load.y_term = TERM_BITS'(j_mag);

endmodule

// ----- rtl/caip_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caip_checker: port-level checks of the arc step interpolator
// Watches the channels and the result word over time; bound to the top.
// ----------------------------------------------------------------------------
module caip_checker import caip_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_step_valid,
  input logic       out_step_axis,
  input logic       out_step_reverse,
  input logic       out_run_done
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // Every accepted word shows its result in the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  // Without a step pulse, axis and direction read zero
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_step_valid |-> !out_step_axis && !out_step_reverse)
    else $error("axis or direction set without a step");

  // A load never steps
  a_load_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_LOAD) |=> !out_step_valid)
    else $error("load word produced a step");

  // An abort ends the run at once
  a_abort_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_ABORT) |=> out_run_done && !out_step_valid)
    else $error("abort did not end the run");

endmodule

bind circular_arc_step_interpolator caip_checker u_caip_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_opcode       (in_opcode),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_step_valid  (out_step_valid),
  .out_step_axis   (out_step_axis),
  .out_step_reverse(out_step_reverse),
  .out_run_done    (out_run_done)
);
